// ----- src/skl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and codes for the sorted keyed list.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int LIST_DEPTH_DEF = 16;

  localparam int REQ_W    = 3;
  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE_LAST = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_AT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ_AT     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd4;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } skl_state_t;

  typedef struct packed {
    logic take;
    logic exec;
  } skl_cmd_t;

endpackage
`default_nettype wire

// ----- src/skl_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skl_ctrl
// Request sequencing and result handshake for the sorted keyed list.
// ----------------------------------------------------------------------------
module skl_ctrl
  import skl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output skl_cmd_t      cmd
);

  skl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_EXEC: cmd.exec = !out_busy;
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- src/skl_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skl_dp
// Row of key/handle cells with parallel compare and shift, request
// register and result register.
// ----------------------------------------------------------------------------
module skl_dp
  import skl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire skl_cmd_t            cmd,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [KEY_W-1:0]    in_sort_key,
  input  wire logic [HANDLE_W-1:0] in_entry_handle,
  input  wire logic [POS_W-1:0]    in_position,
  output logic [HANDLE_W-1:0]      out_handle,
  output logic [KEY_W-1:0]         out_key,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_entry_count
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [REQ_W-1:0]    req_r;
  logic [KEY_W-1:0]    new_key_r;
  logic [HANDLE_W-1:0] new_handle_r;
  logic [POS_W-1:0]    pos_r;

  logic [KEY_W-1:0]    key_r    [LIST_DEPTH];
  logic [HANDLE_W-1:0] handle_r [LIST_DEPTH];
  logic [KEY_W-1:0]    key_nxt    [LIST_DEPTH];
  logic [HANDLE_W-1:0] handle_nxt [LIST_DEPTH];
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic [CMP_W-1:0]    pos_e, cnt_e, slot_e;
  logic [IDX_W-1:0]    rd_idx;
  logic                full, hit, do_ins, do_del;
  logic [LIST_DEPTH-1:0] le, prev_le;
  logic [STATUS_W-1:0] status_nxt;

  assign pos_e = CMP_W'(pos_r);
  assign cnt_e = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(LIST_DEPTH));

  always_comb begin
    hit        = 1'b0;
    slot_e     = '0;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    status_nxt = STS_OK;
    count_nxt  = count_r;
    case (req_r)
      REQ_INSERT: begin
        if (full) begin
          status_nxt = STS_FULL;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      REQ_REMOVE_LAST: begin
        slot_e = cnt_e - 1'b1;
        hit    = (count_r != '0);
      end
      REQ_REMOVE_AT: begin
        slot_e = (pos_r == '0) ? '0 : pos_e - 1'b1;
        hit    = (slot_e < cnt_e);
        do_del = hit;
      end
      REQ_READ_AT: begin
        slot_e = pos_e - 1'b1;
        hit    = (pos_r != '0) && (pos_e <= cnt_e);
      end
      REQ_CLEAR: count_nxt = '0;
      default: status_nxt = STS_OK;
    endcase
    if ((req_r == REQ_REMOVE_LAST) || (req_r == REQ_REMOVE_AT) ||
        (req_r == REQ_READ_AT)) begin
      if (!hit) status_nxt = STS_MISSING;
      else if (req_r != REQ_READ_AT) count_nxt = count_r - 1'b1;
    end
  end

  assign rd_idx = slot_e[IDX_W-1:0];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    assign le[i] = (IDX < cnt_e) && (key_r[i] <= new_key_r);
    if (i == 0) begin : g_first
      assign prev_le[i] = 1'b1;
    end else begin : g_rest
      assign prev_le[i] = le[i-1];
    end

    always_comb begin
      key_nxt[i]    = key_r[i];
      handle_nxt[i] = handle_r[i];
      if (do_ins && !le[i]) begin
        if (prev_le[i]) begin
          key_nxt[i]    = new_key_r;
          handle_nxt[i] = new_handle_r;
        end else begin
          key_nxt[i]    = key_r[(i > 0) ? i - 1 : 0];
          handle_nxt[i] = handle_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del && (IDX >= slot_e) && (i < LIST_DEPTH - 1)) begin
        key_nxt[i]    = key_r[(i < LIST_DEPTH - 1) ? i + 1 : i];
        handle_nxt[i] = handle_r[(i < LIST_DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        key_r[i]    <= key_nxt[i];
        handle_r[i] <= handle_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r        <= in_req_type;
      new_key_r    <= in_sort_key;
      new_handle_r <= in_entry_handle;
      pos_r        <= in_position;
    end
    if (cmd.exec) begin
      out_handle      <= hit ? handle_r[rd_idx] : '0;
      out_key         <= hit ? key_r[rd_idx] : '0;
      out_status      <= status_nxt;
      out_entry_count <= COUNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/sorted_keyed_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_keyed_list
// Sorted list of (key, handle) entries with insert, remove, read and clear.
// ----------------------------------------------------------------------------
// Each request is captured (ST_IDLE), then applied (ST_EXEC): every cell
// compares its key against the new key (or its index against the target
// position) and shifts in parallel, while the result register is loaded.
// A request is taken while the previous result still waits on out_stall; the
// apply cycle holds only until that result register is free. Keys are
// unsigned 8.8 values compared as plain 16-bit numbers; equal keys keep
// arrival order. entry_count wraps modulo 32 for depths above 31.
// ----------------------------------------------------------------------------
module sorted_keyed_list
  import skl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [REQ_W-1:0]    in_req_type,
  input  wire logic [KEY_W-1:0]    in_sort_key,
  input  wire logic [HANDLE_W-1:0] in_entry_handle,
  input  wire logic [POS_W-1:0]    in_position,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [HANDLE_W-1:0]      out_handle,
  output logic [KEY_W-1:0]         out_key,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_entry_count
);

  skl_cmd_t cmd;

  skl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skl_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_sort_key     (in_sort_key),
    .in_entry_handle (in_entry_handle),
    .in_position     (in_position),
    .out_handle      (out_handle),
    .out_key         (out_key),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire

// ----- src/skl_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skl_props
// Port-level checks for the sorted keyed list, bound to the top level.
// ----------------------------------------------------------------------------
module skl_props
  import skl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic [REQ_W-1:0]    in_req_type,
  input wire logic [KEY_W-1:0]    in_sort_key,
  input wire logic [HANDLE_W-1:0] in_entry_handle,
  input wire logic [POS_W-1:0]    in_position,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [HANDLE_W-1:0] out_handle,
  input wire logic [KEY_W-1:0]    out_key,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [COUNT_W-1:0]  out_entry_count
);

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(LIST_DEPTH);

  a_stall_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STS_OK) || (out_status == STS_MISSING) ||
                  (out_status == STS_FULL))
    else $error("bad status code");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_FULL) |-> out_entry_count == DEPTH_CNT)
    else $error("full reported with wrong count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |-> (out_handle == '0) && (out_key == '0))
    else $error("payload not zero on failed request");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (LIST_DEPTH > 31) || (out_entry_count <= DEPTH_CNT))
    else $error("entry count above depth");

endmodule

bind sorted_keyed_list skl_props #(.LIST_DEPTH(LIST_DEPTH)) u_skl_props (.*);
`default_nettype wire
